/* design/asau_pkg.sv */
// Shared types, constants and helpers of the atlas section allocator.
`timescale 1ns / 1ps
package asau_pkg;

  localparam int MAX_ATLASES  = 8;
  localparam int ATLAS_W      = 3;
  localparam int CNT_W        = 4;
  localparam int SECTIONS     = 32;
  localparam int SEC_W        = 5;
  localparam int USED_W       = 6;
  localparam int COLS         = 16;
  localparam int COL_W        = 4;
  localparam int ROW_W        = 1;
  localparam int TICK_W       = 8;
  localparam int KEEP_W       = 4;
  localparam int LIMIT_W      = 8;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [KEEP_W-1:0]  KEEP_RESET  = 4'd4;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd10;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_TICK    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_GRANT     = 3'd0,
    ST_GRANT_NEW = 3'd1,
    ST_NO_ROOM   = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_REL_ERROR = 3'd4,
    ST_DELETED   = 3'd5
  } status_e;

  // Register index, taken from the word address.
  typedef enum logic {
    REG_KEEP_AROUND = 1'b0,
    REG_EMPTY_LIMIT = 1'b1
  } reg_e;

  // One atlas entry as stored in the entry memory.
  typedef struct packed {
    logic [SECTIONS-1:0] map;
    logic [USED_W-1:0]   used;
    logic [TICK_W-1:0]   ticks;
  } entry_t;

  // Lowest clear bit of a section map.
  function automatic logic [SEC_W-1:0] first_free(input logic [SECTIONS-1:0] map);
    logic [SEC_W-1:0] s;
    s = '0;
    for (int k = SECTIONS - 1; k >= 0; k--) begin
      if (!map[k]) s = SEC_W'(k);
    end
    return s;
  endfunction

endpackage

/* design/asau_if.sv */
// Item channels of the atlas section allocator.
`timescale 1ns / 1ps
interface asau_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [asau_pkg::ATLAS_W-1:0] atlas_index;
  logic [asau_pkg::SEC_W-1:0]   section_index;

  modport source (output valid, kind, atlas_index, section_index, input ready);
  modport sink   (input valid, kind, atlas_index, section_index, output ready);
endinterface

interface asau_res_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic [asau_pkg::ATLAS_W-1:0] result_atlas;
  logic [asau_pkg::SEC_W-1:0]   result_section;
  logic [asau_pkg::COL_W-1:0]   section_column;
  logic [asau_pkg::ROW_W-1:0]   section_row;
  logic [asau_pkg::ATLAS_W-1:0] moved_from;
  logic                         last;

  modport source (output valid, status, result_atlas, result_section, section_column,
                  section_row, moved_from, last, input ready);
  modport sink   (input valid, status, result_atlas, result_section, section_column,
                  section_row, moved_from, last, output ready);
endinterface

/* design/asau_entry_ram.sv */
// Atlas entry memory: one write port, one registered read port.
`timescale 1ns / 1ps
module asau_entry_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [asau_pkg::ATLAS_W-1:0] waddr_i,
  input  asau_pkg::entry_t             wdata_i,
  input  logic [asau_pkg::ATLAS_W-1:0] raddr_i,
  output asau_pkg::entry_t             rdata_o
);

  asau_pkg::entry_t mem [asau_pkg::MAX_ATLASES];
  asau_pkg::entry_t rdata_q;

  // Write one entry.
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // Read one entry; the data appears in the next cycle.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/atlas_section_allocator_unit.sv */
// Top level of the atlas section allocator.
// Handles one item at a time. The entry memory address is set in the cycle
// before an atlas is visited, so each atlas visit first waits for the
// registered read, then evaluates and writes back. An allocate walks the
// atlases from the first, and appends an atlas or reports no room when
// none has a free section. A release of an atlas beyond the atlas count
// is reported as an error with no memory read. A tick walks the atlases
// from the last down to the first, and a deletion that moves the last
// atlas adds a read and a write of that entry; with no atlases it ends at
// once. The next item is accepted in the cycle after the result is
// loaded, so it is taken while the result waits; the block stalls only when
// it must hand over a new result and that register is still full. Atlas
// entries live in an 8-entry memory; entries beyond the atlas count are
// always rewritten before use, so no clearing pass runs.
`timescale 1ns / 1ps
module atlas_section_allocator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  asau_req_if.sink                      req_i,
  asau_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [asau_pkg::PADDR_W-1:0]  paddr,
  input  logic [asau_pkg::PDATA_W-1:0]  pwdata,
  output logic [asau_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_A_WT, S_A_EV, S_A_NEW, S_R_WT, S_R_EV,
    S_T_WT, S_T_EV, S_T_MWT, S_T_MV, S_T_FIN, S_OUT
  } state_e;

  state_e                          state_q;
  logic [asau_pkg::CNT_W-1:0]      cnt_q;
  logic [asau_pkg::ATLAS_W-1:0]    idx_q;
  logic [asau_pkg::ATLAS_W-1:0]    raddr_q;
  logic [asau_pkg::ATLAS_W-1:0]    ai_q;
  logic [asau_pkg::SEC_W-1:0]      si_q;
  logic [asau_pkg::KEEP_W-1:0]     keep_q;
  logic [asau_pkg::LIMIT_W-1:0]    limit_q;

  // Staged single result and pending deletion result.
  asau_pkg::status_e               st_status_q;
  logic [asau_pkg::ATLAS_W-1:0]    st_atlas_q;
  logic [asau_pkg::SEC_W-1:0]      st_sec_q;
  logic                            st_place_q;
  logic [asau_pkg::ATLAS_W-1:0]    st_moved_q;
  logic                            pend_v_q;
  logic [asau_pkg::ATLAS_W-1:0]    pend_atlas_q;
  logic [asau_pkg::ATLAS_W-1:0]    pend_moved_q;

  // Output register.
  logic                            out_v_q;
  logic [2:0]                      out_status_q;
  logic [asau_pkg::ATLAS_W-1:0]    out_atlas_q;
  logic [asau_pkg::SEC_W-1:0]      out_sec_q;
  logic [asau_pkg::COL_W-1:0]      out_col_q;
  logic [asau_pkg::ROW_W-1:0]      out_row_q;
  logic [asau_pkg::ATLAS_W-1:0]    out_moved_q;
  logic                            out_last_q;

  // Memory write port, registered.
  logic                            we_q;
  logic [asau_pkg::ATLAS_W-1:0]    waddr_q;
  asau_pkg::entry_t                wdata_q;
  asau_pkg::entry_t                rdata;

  logic                            out_free;
  logic                            cfg_we;
  logic [asau_pkg::SEC_W-1:0]      free_sec;
  logic [asau_pkg::USED_W-1:0]     rel_used;
  logic [asau_pkg::ATLAS_W-1:0]    cnt_last;

  asau_entry_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we_q),
    .waddr_i (waddr_q),
    .wdata_i (wdata_q),
    .raddr_i (raddr_q),
    .rdata_o (rdata)
  );

  assign out_free = !out_v_q || res_o.ready;
  assign free_sec = asau_pkg::first_free(rdata.map);
  assign rel_used = (rdata.used != '0) ? rdata.used - 1'b1 : rdata.used;
  assign cnt_last = asau_pkg::ATLAS_W'(cnt_q - 1'b1);

  assign req_i.ready = (state_q == S_IDLE);

  assign res_o.valid          = out_v_q;
  assign res_o.status         = out_status_q;
  assign res_o.result_atlas   = out_atlas_q;
  assign res_o.result_section = out_sec_q;
  assign res_o.section_column = out_col_q;
  assign res_o.section_row    = out_row_q;
  assign res_o.moved_from     = out_moved_q;
  assign res_o.last           = out_last_q;

  // Configuration registers.
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (asau_pkg::reg_e'(paddr[2]))
      asau_pkg::REG_KEEP_AROUND: prdata = {{(asau_pkg::PDATA_W-asau_pkg::KEEP_W){1'b0}}, keep_q};
      asau_pkg::REG_EMPTY_LIMIT: prdata = {{(asau_pkg::PDATA_W-asau_pkg::LIMIT_W){1'b0}}, limit_q};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q  <= asau_pkg::KEEP_RESET;
      limit_q <= asau_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (asau_pkg::reg_e'(paddr[2]))
        asau_pkg::REG_KEEP_AROUND: keep_q  <= pwdata[asau_pkg::KEEP_W-1:0];
        asau_pkg::REG_EMPTY_LIMIT: limit_q <= pwdata[asau_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: read, modify and write back one atlas entry per step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      we_q     <= 1'b0;
      idx_q    <= '0;
      raddr_q  <= '0;
    end else begin
      we_q <= 1'b0;
      if (res_o.valid && res_o.ready) out_v_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            ai_q <= req_i.atlas_index;
            si_q <= req_i.section_index;
            unique case (asau_pkg::kind_e'(req_i.kind))
              asau_pkg::KIND_ALLOC: begin
                idx_q   <= '0;
                raddr_q <= '0;
                state_q <= (cnt_q == '0) ? S_A_NEW : S_A_WT;
              end
              asau_pkg::KIND_RELEASE: begin
                if ({1'b0, req_i.atlas_index} >= cnt_q) begin
                  st_status_q <= asau_pkg::ST_REL_ERROR;
                  st_atlas_q  <= req_i.atlas_index;
                  st_sec_q    <= req_i.section_index;
                  st_place_q  <= 1'b0;
                  st_moved_q  <= req_i.atlas_index;
                  state_q     <= S_OUT;
                end else begin
                  raddr_q <= req_i.atlas_index;
                  state_q <= S_R_WT;
                end
              end
              asau_pkg::KIND_TICK: begin
                if (cnt_q != '0) begin
                  idx_q   <= cnt_last;
                  raddr_q <= cnt_last;
                  state_q <= S_T_WT;
                end
              end
              default: ;
            endcase
          end
        end

        S_A_WT: state_q <= S_A_EV;

        S_A_EV: begin
          if (rdata.used < asau_pkg::USED_W'(asau_pkg::SECTIONS)) begin
            we_q          <= 1'b1;
            waddr_q       <= idx_q;
            wdata_q       <= '{map:   rdata.map | (asau_pkg::SECTIONS'(1) << free_sec),
                               used:  rdata.used + 1'b1,
                               ticks: rdata.ticks};
            st_status_q   <= asau_pkg::ST_GRANT;
            st_atlas_q    <= idx_q;
            st_sec_q      <= free_sec;
            st_place_q    <= 1'b1;
            st_moved_q    <= idx_q;
            state_q       <= S_OUT;
          end else if (idx_q == cnt_last) begin
            state_q <= S_A_NEW;
          end else begin
            idx_q   <= idx_q + 1'b1;
            raddr_q <= idx_q + 1'b1;
            state_q <= S_A_WT;
          end
        end

        S_A_NEW: begin
          if (cnt_q < asau_pkg::CNT_W'(asau_pkg::MAX_ATLASES)) begin
            we_q          <= 1'b1;
            waddr_q       <= asau_pkg::ATLAS_W'(cnt_q);
            wdata_q       <= '{map:   asau_pkg::SECTIONS'(1),
                               used:  asau_pkg::USED_W'(1),
                               ticks: '0};
            cnt_q         <= cnt_q + 1'b1;
            st_status_q   <= asau_pkg::ST_GRANT_NEW;
            st_atlas_q    <= asau_pkg::ATLAS_W'(cnt_q);
            st_sec_q      <= '0;
            st_place_q    <= 1'b1;
            st_moved_q    <= asau_pkg::ATLAS_W'(cnt_q);
          end else begin
            st_status_q <= asau_pkg::ST_NO_ROOM;
            st_atlas_q  <= '0;
            st_sec_q    <= '0;
            st_place_q  <= 1'b0;
            st_moved_q  <= '0;
          end
          state_q <= S_OUT;
        end

        S_R_WT: state_q <= S_R_EV;

        S_R_EV: begin
          st_atlas_q <= ai_q;
          st_sec_q   <= si_q;
          st_moved_q <= ai_q;
          if (!rdata.map[si_q]) begin
            st_status_q <= asau_pkg::ST_REL_ERROR;
            st_place_q  <= 1'b0;
          end else begin
            we_q         <= 1'b1;
            waddr_q      <= ai_q;
            // Start the empty counter when an atlas at or above keep-around becomes empty.
            wdata_q      <= '{map:   rdata.map & ~(asau_pkg::SECTIONS'(1) << si_q),
                              used:  rel_used,
                              ticks: (rel_used == '0 && {1'b0, ai_q} >= keep_q) ?
                                     asau_pkg::TICK_W'(1) : rdata.ticks};
            st_status_q <= asau_pkg::ST_RELEASED;
            st_place_q  <= 1'b1;
          end
          state_q <= S_OUT;
        end

        S_T_WT: state_q <= S_T_EV;

        S_T_EV: begin
          priority if (rdata.used != '0 || {1'b0, idx_q} < keep_q) begin
            we_q          <= 1'b1;
            waddr_q       <= idx_q;
            wdata_q       <= '{map: rdata.map, used: rdata.used, ticks: '0};
            if (idx_q == '0) state_q <= S_T_FIN;
            else begin
              idx_q   <= idx_q - 1'b1;
              raddr_q <= idx_q - 1'b1;
              state_q <= S_T_WT;
            end
          end else if (rdata.ticks == '0) begin
            if (idx_q == '0) state_q <= S_T_FIN;
            else begin
              idx_q   <= idx_q - 1'b1;
              raddr_q <= idx_q - 1'b1;
              state_q <= S_T_WT;
            end
          end else if (rdata.ticks > limit_q) begin
            // Delete: flush the earlier deletion first, then move the last atlas unless it is this one.
            if (!pend_v_q || out_free) begin
              if (pend_v_q) begin
                out_v_q      <= 1'b1;
                out_status_q <= asau_pkg::ST_DELETED;
                out_atlas_q  <= pend_atlas_q;
                out_sec_q    <= '0;
                out_col_q    <= '0;
                out_row_q    <= '0;
                out_moved_q  <= pend_moved_q;
                out_last_q   <= 1'b0;
              end
              pend_v_q     <= 1'b1;
              pend_atlas_q <= idx_q;
              pend_moved_q <= cnt_last;
              cnt_q        <= cnt_q - 1'b1;
              if (cnt_last != idx_q) begin
                raddr_q <= cnt_last;
                state_q <= S_T_MWT;
              end else if (idx_q == '0) state_q <= S_T_FIN;
              else begin
                idx_q   <= idx_q - 1'b1;
                raddr_q <= idx_q - 1'b1;
                state_q <= S_T_WT;
              end
            end
          end else begin
            we_q    <= 1'b1;
            waddr_q <= idx_q;
            wdata_q <= '{map:   rdata.map,
                         used:  rdata.used,
                         ticks: (rdata.ticks != '1) ? rdata.ticks + 1'b1 : rdata.ticks};
            if (idx_q == '0) state_q <= S_T_FIN;
            else begin
              idx_q   <= idx_q - 1'b1;
              raddr_q <= idx_q - 1'b1;
              state_q <= S_T_WT;
            end
          end
        end

        S_T_MWT: state_q <= S_T_MV;

        S_T_MV: begin
          we_q    <= 1'b1;
          waddr_q <= idx_q;
          wdata_q <= rdata;
          if (idx_q == '0) state_q <= S_T_FIN;
          else begin
            idx_q   <= idx_q - 1'b1;
            raddr_q <= idx_q - 1'b1;
            state_q <= S_T_WT;
          end
        end

        S_T_FIN: begin
          if (!pend_v_q) state_q <= S_IDLE;
          else if (out_free) begin
            out_v_q      <= 1'b1;
            out_status_q <= asau_pkg::ST_DELETED;
            out_atlas_q  <= pend_atlas_q;
            out_sec_q    <= '0;
            out_col_q    <= '0;
            out_row_q    <= '0;
            out_moved_q  <= pend_moved_q;
            out_last_q   <= 1'b1;
            pend_v_q     <= 1'b0;
            state_q      <= S_IDLE;
          end
        end

        S_OUT: begin
          if (out_free) begin
            out_v_q      <= 1'b1;
            out_status_q <= st_status_q;
            out_atlas_q  <= st_atlas_q;
            out_sec_q    <= st_sec_q;
            out_col_q    <= st_place_q ? asau_pkg::COL_W'(st_sec_q % asau_pkg::COLS) : '0;
            out_row_q    <= st_place_q ? asau_pkg::ROW_W'(st_sec_q / asau_pkg::COLS) : '0;
            out_moved_q  <= st_moved_q;
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
